@@ rtl/upsampling_am_modulator_top_defines.svh @@
// ----------------------------------------------------------------------------
// Upsampling AM modulator assertion macros
// Shared assertion forms, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef UPSAMPLING_AM_MODULATOR_TOP_DEFINES_SVH
`define UPSAMPLING_AM_MODULATOR_TOP_DEFINES_SVH

// same-cycle implication
`define UAM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define UAM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/uam_pkg.sv @@
// ----------------------------------------------------------------------------
// Upsampling AM modulator package
// Widths, reset values, register indexes and control structs.
// ----------------------------------------------------------------------------
package uam_pkg;

	localparam int PHASE_BITS_DEF = 32;
	localparam int FACTOR_W       = 7;
	localparam int STEP_W         = 32;
	localparam int SAMPLE_W       = 8;
	localparam int OUT_W          = 8;
	localparam int CNT_W          = 6;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 32;

	localparam logic [FACTOR_W-1:0] FACTOR_RESET = 7'd40;
	localparam logic [FACTOR_W-1:0] FACTOR_MAX   = 7'd64;
	localparam logic [STEP_W-1:0]   STEP_RESET   = 32'd171798692;

	// 2^22/127 rounded up; exact floor for dividends up to 127*128
	localparam logic [15:0] RECIP_127 = 16'd33027;
	localparam int          RECIP_SH  = 22;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FACTOR = 2'd0,
		REG_STEP   = 2'd1
	} reg_idx_t;

	typedef struct packed {
		logic load;   // latch a new baseband sample
		logic issue;  // launch one output into the datapath
		logic last;   // the launched output ends its run
	} ctrl_cmd_t;

	typedef struct packed {
		logic advance; // pipeline moves this cycle
	} dp_status_t;

endpackage

@@ rtl/uam_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the upsample factor and the phase step, written by index.
// ----------------------------------------------------------------------------
module uam_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [uam_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [uam_pkg::CFG_DATA_W-1:0]   cfg_data,
	output logic [uam_pkg::FACTOR_W-1:0]     factor,
	output logic [uam_pkg::STEP_W-1:0]       phase_step
);

	logic [uam_pkg::FACTOR_W-1:0] factor_q;
	logic [uam_pkg::STEP_W-1:0]   step_q;

	assign cfg_ready  = 1'b1;
	assign factor     = factor_q;
	assign phase_step = step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			factor_q <= uam_pkg::FACTOR_RESET;
			step_q   <= uam_pkg::STEP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				uam_pkg::REG_FACTOR: factor_q <= cfg_data[uam_pkg::FACTOR_W-1:0];
				uam_pkg::REG_STEP:   step_q   <= cfg_data[uam_pkg::STEP_W-1:0];
				default: ; // drop writes to unknown registers
			endcase
		end
	end

endmodule

@@ rtl/uam_ctrl.sv @@
// ----------------------------------------------------------------------------
// Run controller
// Accepts baseband items and launches one output per cycle for each run while the datapath advances.
// ----------------------------------------------------------------------------
module uam_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [uam_pkg::FACTOR_W-1:0] factor,
	input  uam_pkg::dp_status_t          status,
	output uam_pkg::ctrl_cmd_t           cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t                     state_q;
	logic [uam_pkg::CNT_W-1:0]  count_q;
	logic [uam_pkg::CNT_W-1:0]  last_idx_q;
	logic [uam_pkg::CNT_W-1:0]  last_idx;
	logic                       issue;
	logic                       is_last;
	logic                       accept;

	// clamp the factor to 1..64 and keep factor minus one as the index of the last output
	always_comb begin
		if (factor == '0) begin
			last_idx = '0;
		end else if (factor >= uam_pkg::FACTOR_MAX) begin
			last_idx = '1;
		end else begin
			last_idx = uam_pkg::CNT_W'(factor - 7'd1);
		end
	end

	assign issue    = (state_q == ST_RUN) && status.advance;
	assign is_last  = (count_q == last_idx_q);
	// take the next item on the cycle the current run launches its last output
	assign in_ready = (state_q == ST_IDLE) || (issue && is_last);
	assign accept   = in_valid && in_ready;

	assign cmd.load  = accept;
	assign cmd.issue = issue;
	assign cmd.last  = is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			last_idx_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q    <= ST_RUN;
						count_q    <= '0;
						last_idx_q <= last_idx;
					end
				end
				ST_RUN: begin
					if (issue) begin
						if (is_last) begin
							count_q <= '0;
							if (accept) begin
								last_idx_q <= last_idx;
							end else begin
								state_q <= ST_IDLE;
							end
						end else begin
							count_q <= count_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
					count_q <= '0;
				end
			endcase
		end
	end

endmodule

@@ rtl/uam_datapath.sv @@
// ----------------------------------------------------------------------------
// Modulator datapath
// Phase accumulator and five-stage parabolic-sine AM pipeline.
// ----------------------------------------------------------------------------
module uam_datapath #(
	parameter int PHASE_BITS = uam_pkg::PHASE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  uam_pkg::ctrl_cmd_t                  cmd,
	output uam_pkg::dp_status_t                 status,
	input  logic signed [uam_pkg::SAMPLE_W-1:0] baseband_sample,
	input  logic [uam_pkg::STEP_W-1:0]          phase_step,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [uam_pkg::OUT_W-1:0]           modulated_sample,
	output logic                                run_last
);

	localparam int SW = uam_pkg::SAMPLE_W;

	logic                   adv;
	logic [PHASE_BITS-1:0]  phase_q;
	logic [PHASE_BITS-1:0]  step_ext;
	logic signed [SW-1:0]   sample_q;

	// stage 1: carrier phase
	logic [14:0]            u_s1;
	logic                   neg_s1, last_s1, vld_s1;
	logic signed [SW-1:0]   smp_s1;
	// stage 2: u*(32768-u)
	logic [28:0]            sq_s2;
	logic                   neg_s2, last_s2, vld_s2;
	logic signed [SW-1:0]   smp_s2;
	// stage 3: rounded carrier
	logic signed [7:0]      c_s3;
	logic                   last_s3, vld_s3;
	logic signed [SW-1:0]   smp_s3;
	// stage 4: |c*sample|
	logic [13:0]            mag_s4;
	logic                   neg_s4, last_s4, vld_s4;
	// stage 5: output register
	logic [uam_pkg::OUT_W-1:0] out_s5;
	logic                   last_s5, vld_s5;

	logic [30:0]            sq_full;
	logic [35:0]            p127;
	logic [7:0]             q_hi;
	logic [27:0]            r_lo;
	logic                   rnd_up;
	logic [6:0]             mag;
	logic signed [15:0]     cs_prod;
	logic [15:0]            cs_abs;
	logic [29:0]            recip_prod;
	logic [7:0]             quot;
	logic [8:0]             sum;

	generate
		if (PHASE_BITS > uam_pkg::STEP_W) begin : g_step_wide
			assign step_ext = {{(PHASE_BITS - uam_pkg::STEP_W){1'b0}}, phase_step};
		end else if (PHASE_BITS == uam_pkg::STEP_W) begin : g_step_eq
			assign step_ext = phase_step;
		end else begin : g_step_narrow
			assign step_ext = phase_step[PHASE_BITS-1:0];
		end
	endgenerate

	// whole pipeline holds while the output register is full and stalled
	assign adv            = !vld_s5 || out_ready;
	assign status.advance = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (cmd.issue) begin
			phase_q <= phase_q + step_ext;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sample_q <= baseband_sample;
		end
	end

	// combinational pieces between stages
	assign sq_full = u_s1 * (16'd32768 - {1'b0, u_s1});
	assign p127    = ({7'd0, sq_s2} << 7) - {7'd0, sq_s2};
	assign q_hi    = p127[35:28];
	assign r_lo    = p127[27:0];
	assign rnd_up  = (r_lo > 28'h8000000) || ((r_lo == 28'h8000000) && q_hi[0]);
	assign mag     = 7'(q_hi + {7'd0, rnd_up});

	assign cs_prod = c_s3 * smp_s3;
	assign cs_abs  = cs_prod[15] ? 16'(-cs_prod) : cs_prod;

	assign recip_prod = mag_s4 * uam_pkg::RECIP_127;
	assign quot       = recip_prod[uam_pkg::RECIP_SH +: 8];
	assign sum        = neg_s4 ? (9'd128 - {1'b0, quot}) : (9'd128 + {1'b0, quot});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= cmd.issue;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			u_s1    <= phase_q[PHASE_BITS-2 -: 15];
			neg_s1  <= phase_q[PHASE_BITS-1];
			smp_s1  <= sample_q;
			last_s1 <= cmd.last;

			sq_s2   <= sq_full[28:0];
			neg_s2  <= neg_s1;
			smp_s2  <= smp_s1;
			last_s2 <= last_s1;

			c_s3    <= neg_s2 ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
			smp_s3  <= smp_s2;
			last_s3 <= last_s2;

			mag_s4  <= cs_abs[13:0];
			neg_s4  <= cs_prod[15];
			last_s4 <= last_s3;

			// only +128 can overflow the offset sum
			out_s5  <= sum[8] ? 8'd255 : sum[7:0];
			last_s5 <= last_s4;
		end
	end

	assign out_valid        = vld_s5;
	assign modulated_sample = out_s5;
	assign run_last         = last_s5;

endmodule

@@ rtl/upsampling_am_modulator_top.sv @@
// An accepted item is latched, then each of its outputs passes through datapath stages s1 to s5.
// Throughput: one output per cycle unless out_ready stalls the full output register;
// an item yields upsample_factor outputs (1..64, 40 by default), one per controller launch.
// Reset (arst_n low): phase accumulator and run counter clear, registers take
// factor 40 and step 171798692, pipeline empties.
// ----------------------------------------------------------------------------
// Upsampling AM modulator
// Zero-order-hold upsampler with parabolic-sine NCO amplitude modulation.
// ----------------------------------------------------------------------------
module upsampling_am_modulator_top #(
	parameter int PHASE_BITS = uam_pkg::PHASE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [uam_pkg::SAMPLE_W-1:0] baseband_sample,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [uam_pkg::OUT_W-1:0]           modulated_sample,
	output logic                                run_last,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [uam_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [uam_pkg::CFG_DATA_W-1:0]      cfg_data
);

	logic [uam_pkg::FACTOR_W-1:0] factor;
	logic [uam_pkg::STEP_W-1:0]   phase_step;
	uam_pkg::ctrl_cmd_t           cmd;
	uam_pkg::dp_status_t          status;

	uam_cfg_regs u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.factor     (factor),
		.phase_step (phase_step)
	);

	uam_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.factor   (factor),
		.status   (status),
		.cmd      (cmd)
	);

	uam_datapath #(
		.PHASE_BITS (PHASE_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.baseband_sample  (baseband_sample),
		.phase_step       (phase_step),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.modulated_sample (modulated_sample),
		.run_last         (run_last)
	);

endmodule

@@ rtl/uam_checker.sv @@
// ----------------------------------------------------------------------------
// Upsampling AM modulator port checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "upsampling_am_modulator_top_defines.svh"

module uam_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic signed [uam_pkg::SAMPLE_W-1:0] baseband_sample,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic [uam_pkg::OUT_W-1:0]           modulated_sample,
	input logic                                run_last,
	input logic                                cfg_valid,
	input logic                                cfg_ready
);

	logic                      in_stall;
	logic                      out_stall;
	logic [uam_pkg::OUT_W:0]   out_item;

	assign in_stall  = in_valid && !in_ready;
	assign out_stall = out_valid && !out_ready;
	assign out_item  = {modulated_sample, run_last};

	// a stalled result keeps its value and its end-of-run flag
	`UAM_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_item), "stalled item changed")

	// a waiting input item stays offered and unchanged
	`UAM_ASSERT_NEXT(a_in_hold, in_stall, in_valid && $stable(baseband_sample), "waiting item changed")

	// once ready for input with nothing offered, the block stays ready
	`UAM_ASSERT_NEXT(a_idle_stays, in_ready && !in_valid, in_ready, "ready dropped while idle")

	// register writes never stall
	`UAM_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready, "configuration write stalled")

endmodule

bind upsampling_am_modulator_top uam_checker u_uam_checker (.*);

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// Upsampling AM modulator regression
// Drives baseband items and register writes with random gaps and back
// pressure. A cycle-free NCO predictor builds each run of expected outputs,
// and every output item is checked against it in order.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_HALF     = 4;
	localparam int RESET_CYCLES = 7;
	localparam int DRAIN_CYCLES = 8;
	localparam int RAND_PHASES  = 10;
	localparam int RAND_ITEMS   = 10;
	localparam int DIR_ROWS     = 26;
	localparam int HI_W         = uam_pkg::CFG_DATA_W - uam_pkg::FACTOR_W;

	// indexes past the register list
	localparam logic [uam_pkg::CFG_IDX_W-1:0] REG_SPARE2 = 2'd2;
	localparam logic [uam_pkg::CFG_IDX_W-1:0] REG_SPARE3 = 2'd3;

	typedef enum logic {
		ROW_ITEM,
		ROW_CFG
	} row_kind_t;

	typedef struct packed {
		row_kind_t                       kind;
		logic [uam_pkg::CFG_IDX_W-1:0]   idx;
		logic [uam_pkg::CFG_DATA_W-1:0]  data;
		logic [uam_pkg::SAMPLE_W-1:0]    sample;
		logic                            typed;
		logic [uam_pkg::OUT_W-1:0]       level;
	} stim_row_t;

	typedef struct packed {
		logic [uam_pkg::OUT_W-1:0] level;
		logic                      last;
	} mod_out_t;

	// Phase walk: reset step leaves 0x999999A0 after 40 outputs; the next
	// step lands on 0xC0000000, then a half-turn step toggles between the
	// carrier's negative and positive peaks.
	localparam stim_row_t DIRECTED [DIR_ROWS] = '{
		'{ROW_ITEM, uam_pkg::REG_FACTOR, 32'h0,        8'h00, 1'b1, 8'd128},
		'{ROW_CFG,  uam_pkg::REG_FACTOR, 32'd1,        8'h00, 1'b0, 8'd0},
		'{ROW_CFG,  uam_pkg::REG_STEP,   32'h26666660, 8'h00, 1'b0, 8'd0},
		'{ROW_ITEM, uam_pkg::REG_FACTOR, 32'h0,        8'h00, 1'b1, 8'd128},
		'{ROW_CFG,  uam_pkg::REG_STEP,   32'h0,        8'h00, 1'b0, 8'd0},
		// negative peak times most negative sample saturates high
		'{ROW_ITEM, uam_pkg::REG_FACTOR, 32'h0,        8'h80, 1'b1, 8'd255},
		'{ROW_ITEM, uam_pkg::REG_FACTOR, 32'h0,        8'h7F, 1'b1, 8'd1},
		'{ROW_CFG,  uam_pkg::REG_STEP,   32'h80000000, 8'h00, 1'b0, 8'd0},
		'{ROW_ITEM, uam_pkg::REG_FACTOR, 32'h0,        8'h7F, 1'b1, 8'd1},
		'{ROW_ITEM, uam_pkg::REG_FACTOR, 32'h0,        8'h7F, 1'b1, 8'd255},
		'{ROW_ITEM, uam_pkg::REG_FACTOR, 32'h0,        8'hFF, 1'b1, 8'd129},
		'{ROW_ITEM, uam_pkg::REG_FACTOR, 32'h0,        8'h80, 1'b1, 8'd0},
		// zero factor runs one output
		'{ROW_CFG,  uam_pkg::REG_FACTOR, 32'd0,        8'h00, 1'b0, 8'd0},
		'{ROW_ITEM, uam_pkg::REG_FACTOR, 32'h0,        8'h80, 1'b1, 8'd255},
		'{ROW_CFG,  uam_pkg::REG_STEP,   32'hFFFFFFFF, 8'h00, 1'b0, 8'd0},
		'{ROW_CFG,  uam_pkg::REG_FACTOR, 32'd127,      8'h00, 1'b0, 8'd0},
		'{ROW_ITEM, uam_pkg::REG_FACTOR, 32'h0,        8'h55, 1'b0, 8'd0},
		'{ROW_CFG,  uam_pkg::REG_FACTOR, 32'd64,       8'h00, 1'b0, 8'd0},
		'{ROW_ITEM, uam_pkg::REG_FACTOR, 32'h0,        8'hAA, 1'b0, 8'd0},
		// writes to unused indexes must leave both registers alone
		'{ROW_CFG,  REG_SPARE3,          32'h0,        8'h00, 1'b0, 8'd0},
		'{ROW_CFG,  REG_SPARE2,          32'hFFFFFFFF, 8'h00, 1'b0, 8'd0},
		'{ROW_ITEM, uam_pkg::REG_FACTOR, 32'h0,        8'h01, 1'b0, 8'd0},
		'{ROW_CFG,  uam_pkg::REG_FACTOR, 32'd65,       8'h00, 1'b0, 8'd0},
		'{ROW_CFG,  uam_pkg::REG_STEP,   32'h0ABCDEF1, 8'h00, 1'b0, 8'd0},
		'{ROW_ITEM, uam_pkg::REG_FACTOR, 32'h0,        8'hFE, 1'b0, 8'd0},
		'{ROW_ITEM, uam_pkg::REG_FACTOR, 32'h0,        8'h33, 1'b0, 8'd0}
	};

	logic                                clk;
	logic                                arst_n;
	logic                                in_valid;
	logic                                in_ready;
	logic signed [uam_pkg::SAMPLE_W-1:0] baseband_sample;
	logic                                out_valid;
	logic                                out_ready;
	logic [uam_pkg::OUT_W-1:0]           modulated_sample;
	logic                                run_last;
	logic                                cfg_valid;
	logic                                cfg_ready;
	logic [uam_pkg::CFG_IDX_W-1:0]       cfg_index;
	logic [uam_pkg::CFG_DATA_W-1:0]      cfg_data;

	// predictor state
	logic [uam_pkg::FACTOR_W-1:0] nco_factor;
	logic [uam_pkg::STEP_W-1:0]   nco_step;
	logic [31:0]                  nco_phase;

	mod_out_t pending_outputs[$];
	int       fail_count;

	upsampling_am_modulator_top dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.baseband_sample  (baseband_sample),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.modulated_sample (modulated_sample),
		.run_last         (run_last),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("upsampling_am_modulator_top regression: fail");
		$finish;
	end

	// parabolic sine on the top 16 phase bits, magnitude rounded half to even
	function automatic int carrier_level(input logic [31:0] ph);
		logic [15:0] top;
		logic [63:0] u;
		logic [63:0] prod;
		logic [63:0] q;
		logic [27:0] rem;
		int          mag;
		top  = ph[31:16];
		u    = 64'(top[14:0]);
		prod = 64'd127 * u * (64'd32768 - u);
		q    = prod >> 28;
		rem  = prod[27:0];
		if (rem > 28'h8000000 || (rem == 28'h8000000 && q[0]))
			q = q + 64'd1;
		mag = int'(q);
		return top[15] ? -mag : mag;
	endfunction

	// queue the run of outputs for one accepted sample and advance the phase
	task automatic nco_predict_run(input logic [uam_pkg::SAMPLE_W-1:0] raw,
			input logic typed, input logic [uam_pkg::OUT_W-1:0] typed_level);
		int       n;
		int       s;
		int       v;
		mod_out_t o;
		n = int'(nco_factor);
		if (n == 0)
			n = 1;
		if (n > int'(uam_pkg::FACTOR_MAX))
			n = int'(uam_pkg::FACTOR_MAX);
		s = int'($signed(raw));
		for (int k = 0; k < n; k++) begin
			v = 128 + (carrier_level(nco_phase) * s) / 127;
			if (v > 255)
				v = 255;
			if (v < 0)
				v = 0;
			o.level = typed ? typed_level : uam_pkg::OUT_W'(v);
			o.last  = (k == n - 1);
			pending_outputs.push_back(o);
			nco_phase = nco_phase + nco_step;
		end
	endtask

	function automatic int gap_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// call and return at a falling edge
	task automatic send_sample(input logic [uam_pkg::SAMPLE_W-1:0] raw, input logic typed,
			input logic [uam_pkg::OUT_W-1:0] typed_level, input int gap);
		if (gap != 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		baseband_sample = raw;
		in_valid        = 1'b1;
		do @(posedge clk); while (!in_ready);
		nco_predict_run(raw, typed, typed_level);
		@(negedge clk);
	endtask

	// drop valid, drain every pending output, then let the pipeline settle
	task automatic wait_idle();
		in_valid = 1'b0;
		while (pending_outputs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [uam_pkg::CFG_IDX_W-1:0] idx,
			input logic [uam_pkg::CFG_DATA_W-1:0] d);
		cfg_index = idx;
		cfg_data  = d;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		if (idx == uam_pkg::REG_FACTOR)
			nco_factor = d[uam_pkg::FACTOR_W-1:0];
		else if (idx == uam_pkg::REG_STEP)
			nco_step = d[uam_pkg::STEP_W-1:0];
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// output pacing: short and long stalls, with long ready stretches
	initial begin : rx_pacer
		int   hold;
		int   pick;
		logic level;
		hold      = 0;
		level     = 1'b0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold == 0) begin
				pick = $urandom_range(0, 99);
				if (pick < 45) begin
					level = 1'b1;
					hold  = $urandom_range(1, 30);
				end else if (pick < 80) begin
					level = 1'b0;
					hold  = $urandom_range(1, 3);
				end else if (pick < 92) begin
					level = 1'b1;
					hold  = $urandom_range(40, 120);
				end else begin
					level = 1'b0;
					hold  = $urandom_range(10, 40);
				end
			end
			hold--;
			out_ready = level;
		end
	end

	always @(posedge clk) begin : out_check
		mod_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_outputs.size() == 0) begin
				$display("%0t ERROR unexpected output item: level %0d last %0b",
					$time, modulated_sample, run_last);
				fail_count++;
			end else begin
				want = pending_outputs.pop_front();
				if (modulated_sample !== want.level) begin
					$display("%0t ERROR modulated_sample: expected %0d, got %0d",
						$time, want.level, modulated_sample);
					fail_count++;
				end
				if (run_last !== want.last) begin
					$display("%0t ERROR run_last: expected %0b, got %0b",
						$time, want.last, run_last);
					fail_count++;
				end
			end
		end
	end

	initial begin : stimulus
		stim_row_t                      row;
		logic                           no_gaps;
		int                             pick;
		logic [uam_pkg::CFG_DATA_W-1:0] d;
		logic [uam_pkg::SAMPLE_W-1:0]   raw;
		fail_count      = 0;
		arst_n          = 1'b0;
		in_valid        = 1'b0;
		baseband_sample = '0;
		cfg_valid       = 1'b0;
		cfg_index       = uam_pkg::REG_FACTOR;
		cfg_data        = '0;
		nco_factor      = uam_pkg::FACTOR_RESET;
		nco_step        = uam_pkg::STEP_RESET;
		nco_phase       = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < DIR_ROWS; i++) begin
			row = DIRECTED[i];
			if (row.kind == ROW_CFG) begin
				wait_idle();
				write_reg(row.idx, row.data);
			end else begin
				send_sample(row.sample, row.typed, row.level, gap_cycles());
			end
		end

		for (int p = 0; p < RAND_PHASES; p++) begin
			wait_idle();
			pick = $urandom_range(0, 9);
			if (pick == 0)
				d = 32'd0;
			else if (pick == 1)
				d = 32'(uam_pkg::FACTOR_MAX);
			else if (pick == 2)
				d = $urandom_range(65, 127);
			else
				d = $urandom_range(1, 12);
			// upper data bits are don't-care for the factor
			d[uam_pkg::CFG_DATA_W-1:uam_pkg::FACTOR_W] = HI_W'($urandom);
			write_reg(uam_pkg::REG_FACTOR, d);
			pick = $urandom_range(0, 9);
			if (pick == 0)
				d = 32'd0;
			else if (pick == 1)
				d = 32'hFFFFFFFF;
			else if (pick == 2)
				d = $urandom_range(0, 255);
			else
				d = $urandom;
			write_reg(uam_pkg::REG_STEP, d);
			if ($urandom_range(0, 3) == 0)
				write_reg($urandom_range(0, 1) ? REG_SPARE2 : REG_SPARE3, $urandom);
			no_gaps = ($urandom_range(0, 3) == 0);
			for (int j = 0; j < RAND_ITEMS; j++) begin
				pick = $urandom_range(0, 15);
				if (pick == 0)
					raw = 8'h80;
				else if (pick == 1)
					raw = 8'h7F;
				else
					raw = uam_pkg::SAMPLE_W'($urandom_range(0, 255));
				send_sample(raw, 1'b0, 8'd0, no_gaps ? 0 : gap_cycles());
			end
		end

		in_valid = 1'b0;
		while (pending_outputs.size() != 0)
			@(posedge clk);
		repeat (4 * DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("upsampling_am_modulator_top regression: pass");
		else
			$display("upsampling_am_modulator_top regression: fail");
		$finish;
	end

endmodule
